// ----- src/ssc_pkg.sv -----
// Package for the sedimentation substep column unit: sequencer codes and field widths.
package ssc_pkg;

  localparam int unsigned StepBits = 7;

  // Operation codes issued by the sequencer to the shared arithmetic unit.
  typedef enum logic [2:0] {
    OP_MUL,
    OP_DIV,
    OP_IDIV
  } ssc_op_e;

  // Configuration register indexes.
  localparam logic CfgTimeStep     = 1'b0;
  localparam logic CfgDivisorFloor = 1'b1;

endpackage

// ----- src/sedimentation_substep_column_unit.sv -----
// Top level of the sedimentation substep column unit: sequencer and shared multiply/divide unit.
//
// Channel    | Direction | Handshake            | Payload
// s_axis     | in        | s_axis_tvalid/tready | tdata: density, thickness, speed_factor,
//            |           |                      |   amount, fall_in, column_steps,
//            |           |                      |   substep_index; tuser: first_level, is_number
// m_axis     | out       | m_axis_tvalid/tready | tdata: amount_out, fall_out
// cfg        | in        | cfg_valid_i/ready_o  | cfg_index_i, cfg_data_i
//
// One word runs a fixed program of up to twelve operations on one shared unit.
// A multiply completes combinationally and a divide goes through load, one quotient bit per
// cycle and result, so the serial divider sets the run time: a mass species below the
// top level needs five divides, a number species below the top three, a mass top level
// two and a number top level one. With a ready sink the next word is accepted once the
// result has been taken. The input is not ready while a word is worked on or while its
// result waits, so a stalled output holds the whole unit. Reset clears the control
// state, the remembered upper level and the configuration registers to their reset
// values.
module sedimentation_substep_column_unit #(
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned FRAC_BITS  = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // density, thickness, speed_factor, amount, fall_in, column_steps, substep_index
  input  logic [5*VALUE_BITS+14+((8-((5*VALUE_BITS+14)%8))%8)-1:0] s_axis_tdata,
  // first_level, is_number
  input  logic [1:0]                s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // amount_out, fall_out
  output logic [2*VALUE_BITS-1:0]   m_axis_tdata,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_index_i,
  input  logic [VALUE_BITS-1:0]     cfg_data_i
);
  import ssc_pkg::*;

  localparam int unsigned VB = VALUE_BITS;
  localparam int unsigned DB = VB + FRAC_BITS;   // dividend width
  localparam int unsigned CB = $clog2(DB + 1);
  localparam logic [VB-1:0] OnesV = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } state_e;

  // Program steps of the sequencer.
  typedef enum logic [3:0] {
    P_F1, P_F2, P_F3, P_OWN1, P_OWN2, P_A1, P_A2, P_A3, P_A4, P_A5, P_A6, P_A7, P_DONE
  } pc_e;

  state_e state_q;
  pc_e    pc_q;
  logic   busy_q;          // shared unit in a divide
  logic   [CB-1:0] cnt_q;
  logic   [DB-1:0] dvd_q;  // dividend being shifted out
  logic   [VB-1:0] rem_q;
  logic   [DB-1:0] quo_q;
  logic   [VB-1:0] dvs_q;
  logic   [VB-1:0] acc_q;  // result of the last operation, except the ratio step

  // Latched word.
  logic first_q, num_q, gate_q;
  logic [VB-1:0] dens_q, thick_q, spd_q, amt_q, fall_q, dsafe_q, zsafe_q;
  logic [StepBits-1:0] steps_q;
  logic [VB-1:0] f_q, own_q, ratio_q;
  logic [VB-1:0] ab_amt_q, ab_dens_q, ab_spd_q, ab_thick_q;
  logic [VB-1:0] ts_q, floor_q;
  logic [2*VB-1:0] out_q;
  logic out_valid_q;

  // Input unpacking.
  logic [VB-1:0] in_dens, in_thick, in_spd, in_amt, in_fall;
  logic [StepBits-1:0] in_steps, in_idx, steps_eff;
  logic [VB-1:0] floor_eff;
  assign in_dens  = s_axis_tdata[0*VB +: VB];
  assign in_thick = s_axis_tdata[1*VB +: VB];
  assign in_spd   = s_axis_tdata[2*VB +: VB];
  assign in_amt   = s_axis_tdata[3*VB +: VB];
  assign in_fall  = s_axis_tdata[4*VB +: VB];
  assign in_steps = s_axis_tdata[5*VB +: StepBits];
  assign in_idx   = s_axis_tdata[5*VB+StepBits +: StepBits];
  assign steps_eff = (in_steps == '0) ? StepBits'(1) : in_steps;
  assign floor_eff = (floor_q == '0) ? VB'(1) : floor_q;

  assign s_axis_tready = (state_q == ST_IDLE) || (state_q == ST_WAIT && !m_axis_tvalid);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = (state_q == ST_WAIT) && out_valid_q;
  assign m_axis_tdata  = out_q;

  // Shared unit: operand selection per program step.
  ssc_op_e op;
  logic [VB-1:0] opa, opb;
  always_comb begin
    op  = OP_MUL;
    opa = acc_q;
    opb = spd_q;
    case (pc_q)
      P_F1:   begin op = num_q ? OP_MUL : OP_MUL; opa = num_q ? amt_q : dens_q;
                    opb = num_q ? spd_q : amt_q; end
      P_F2:   begin op = OP_MUL; opa = acc_q; opb = num_q ? OnesV : spd_q; end
      P_F3:   begin op = OP_IDIV; opa = acc_q; opb = VB'(steps_q); end
      P_OWN1: begin op = OP_MUL; opa = f_q; opb = ts_q; end
      P_OWN2: begin op = OP_DIV; opa = acc_q; opb = dsafe_q; end
      P_A1:   begin op = OP_MUL; opa = num_q ? ab_amt_q : ab_dens_q;
                    opb = num_q ? ab_spd_q : ab_amt_q; end
      P_A2:   begin op = OP_MUL; opa = acc_q; opb = num_q ? OnesV : ab_spd_q; end
      P_A3:   begin op = OP_IDIV; opa = acc_q; opb = VB'(steps_q); end
      P_A4:   begin op = OP_DIV; opa = ab_thick_q; opb = zsafe_q; end
      P_A5:   begin op = OP_MUL; opa = acc_q; opb = ratio_q; end
      P_A6:   begin op = OP_MUL; opa = acc_q; opb = ts_q; end
      P_A7:   begin op = OP_DIV; opa = acc_q; opb = dsafe_q; end
      default: begin op = OP_MUL; end
    endcase
  end

  // The pass-through multiply for number species (times all-ones) is not exact, so
  // steps F2/A2 are bypassed for them below.
  logic [2*VB-1:0] prod;
  logic [VB-1:0]   mul_res;
  assign prod    = opa * opb;
  assign mul_res = (prod[2*VB-1:FRAC_BITS] > {{(VB-FRAC_BITS){1'b0}}, OnesV})
                   ? OnesV : prod[FRAC_BITS +: VB];

  // Divider step: restoring, one quotient bit per cycle.
  logic [VB:0] rem_sh, rem_sub;
  logic        take;
  assign rem_sh  = {rem_q, dvd_q[DB-1]};
  assign take    = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = take ? rem_sh - {1'b0, dvs_q} : rem_sh;

  logic is_div;
  assign is_div = (op != OP_MUL);

  // Result of a finished divide, saturated.
  logic [VB-1:0] div_res;
  assign div_res = (quo_q[DB-1:VB] != '0) ? OnesV : quo_q[VB-1:0];

  logic [VB-1:0] step_res;   // value produced this cycle when a step completes
  logic          step_done;
  always_comb begin
    step_done = 1'b0;
    step_res  = mul_res;
    if (!is_div) begin
      step_done = 1'b1;
      if ((pc_q == P_F2 || pc_q == P_A2) && num_q) step_res = acc_q;
    end else if (busy_q && cnt_q == '0) begin
      step_done = 1'b1;
      step_res  = div_res;
    end
  end

  // Next program step, skipping steps that do not apply.
  pc_e pc_next;
  always_comb begin
    pc_next = P_DONE;
    case (pc_q)
      P_F1:   pc_next = P_F2;
      P_F2:   pc_next = P_F3;
      P_F3:   pc_next = P_OWN1;
      P_OWN1: pc_next = num_q ? (first_q ? P_DONE : P_A1) : P_OWN2;
      P_OWN2: pc_next = first_q ? P_DONE : P_A1;
      P_A1:   pc_next = P_A2;
      P_A2:   pc_next = P_A3;
      P_A3:   pc_next = P_A4;
      P_A4:   pc_next = P_A5;
      P_A5:   pc_next = P_A6;
      P_A6:   pc_next = num_q ? P_DONE : P_A7;
      P_A7:   pc_next = P_DONE;
      default: pc_next = P_DONE;
    endcase
  end

  // Final combination.
  logic [VB-1:0] own_min, infl, diff, res_amt, res_fall;
  logic [VB:0]   sum_a, sum_f;
  always_comb begin
    infl = '0;
    if (!first_q) infl = (acc_q < ab_amt_q) ? acc_q : ab_amt_q;
    own_min  = (own_q < amt_q) ? own_q : amt_q;
    diff     = amt_q - own_min;
    sum_a    = {1'b0, diff} + {1'b0, infl};
    res_amt  = sum_a[VB] ? OnesV : sum_a[VB-1:0];
    sum_f    = {1'b0, fall_q} + {1'b0, f_q};
    res_fall = sum_f[VB] ? OnesV : sum_f[VB-1:0];
  end

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= P_F1;
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      ts_q        <= VB'(1) << FRAC_BITS;
      floor_q     <= VB'(1);
      ab_amt_q    <= '0;
      ab_dens_q   <= '0;
      ab_spd_q    <= '0;
      ab_thick_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgTimeStep) ts_q <= cfg_data_i;
        else                            floor_q <= cfg_data_i;
      end
      if (m_axis_tvalid && m_axis_tready) out_valid_q <= 1'b0;
      if (m_axis_tvalid && m_axis_tready && !in_acc) state_q <= ST_IDLE;
      case (state_q)
        ST_IDLE, ST_WAIT: begin
          if (in_acc) begin
            state_q <= ST_RUN;
            pc_q    <= P_F1;
            busy_q  <= 1'b0;
            first_q <= s_axis_tuser[0];
            num_q   <= s_axis_tuser[1];
            dens_q  <= in_dens;
            thick_q <= in_thick;
            spd_q   <= in_spd;
            amt_q   <= in_amt;
            fall_q  <= in_fall;
            steps_q <= steps_eff;
            gate_q  <= steps_eff >= in_idx;
            dsafe_q <= (in_dens < floor_eff) ? floor_eff : in_dens;
            zsafe_q <= (in_thick < floor_eff) ? floor_eff : in_thick;
          end
        end
        ST_RUN: begin
          if (is_div && !busy_q) begin
            busy_q <= 1'b1;
            cnt_q  <= CB'(DB);
            rem_q  <= '0;
            quo_q  <= '0;
            dvs_q  <= opb;
            dvd_q  <= (op == OP_IDIV) ? {{FRAC_BITS{1'b0}}, opa}
                                      : {opa, {FRAC_BITS{1'b0}}};
          end else if (is_div && busy_q && cnt_q != '0) begin
            cnt_q <= cnt_q - 1'b1;
            rem_q <= rem_sub[VB-1:0];
            dvd_q <= dvd_q << 1;
            quo_q <= {quo_q[DB-2:0], take};
          end
          if (step_done) begin
            busy_q <= 1'b0;
            // The ratio step keeps the inflow flux in the accumulator.
            if (pc_q == P_A4) ratio_q <= step_res;
            else if ((pc_q == P_F3 || pc_q == P_A3) && !gate_q) acc_q <= '0;
            else acc_q <= step_res;
            if (pc_q == P_F3) f_q <= gate_q ? step_res : '0;
            if (pc_q == P_OWN1 || pc_q == P_OWN2) own_q <= step_res;
            pc_q <= pc_next;
          end
          if (pc_q == P_DONE) begin
            out_q       <= {res_fall, res_amt};
            out_valid_q <= 1'b1;
            ab_amt_q    <= res_amt;
            ab_dens_q   <= dens_q;
            ab_spd_q    <= spd_q;
            ab_thick_q  <= thick_q;
            state_q     <= ST_WAIT;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  // A result is never shown while a word is still being worked on.
  a_no_out_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RUN |-> !m_axis_tvalid) else $error("result during run");
  // The divider counter only runs down while a divide is in flight.
  a_cnt_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0 && state_q == ST_RUN |-> busy_q) else $error("counter idle");
  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("result moved");
`endif

endmodule
